// ===== src/tld_pkg.sv =====
package tld_pkg;

   // Line store geometry
   localparam int LINE_MAX = 256;
   localparam int ADDR_W   = $clog2(LINE_MAX);
   localparam int FILL_W   = $clog2(LINE_MAX + 1);

   // Field widths
   localparam int OP_W   = 2;
   localparam int BYTE_W = 8;
   localparam int KIND_W = 2;
   localparam int SIG_W  = 2;
   localparam int LEN_W  = 9;
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   // Opcodes
   localparam logic [OP_W-1:0] OP_KEY  = 2'd0;
   localparam logic [OP_W-1:0] OP_HOST = 2'd1;
   localparam logic [OP_W-1:0] OP_READ = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_DISPLAY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SIGNAL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READER  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_LINE    = 2'd3;

   // Signal codes
   localparam logic [SIG_W-1:0] SIG_INTR = 2'd0;
   localparam logic [SIG_W-1:0] SIG_STOP = 2'd1;
   localparam logic [SIG_W-1:0] SIG_QUIT = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_DISPLAY_ATTACHED = 3'd0;
   localparam logic [2:0] REG_SIG_ENABLE       = 3'd1;
   localparam logic [2:0] REG_CANONICAL_MODE   = 3'd2;
   localparam logic [2:0] REG_ECHO_ENABLE      = 3'd3;
   localparam logic [2:0] REG_POST_PROCESS     = 3'd4;
   localparam logic [2:0] REG_NL_TO_CRNL       = 3'd5;

   // Character codes
   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_INTR  = 8'h03;
   localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SUSP  = 8'h1A;
   localparam logic [BYTE_W-1:0] CH_QUIT  = 8'h1C;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

   // One result item
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] out_byte;
      logic [SIG_W-1:0]  signal_code;
      logic [LEN_W-1:0]  line_length;
   } result_type;

endpackage

// ===== src/tty_line_discipline.sv =====
// Terminal line discipline.
// Input channel (req_*): one item per byte: a key byte, a host output byte, or
// a read of the line store at req_read_index. Result channel (rsp_*): zero to
// three result items per input item, rsp_last marks the final one.
// An item that causes no result (dropped key, unused opcode) leaves no trace
// on the result channel.
// The first result of an item is shown the cycle after acceptance.
// Results flow at one per cycle while the receiver does not stall; an item holds
// the result stage until its last result is taken. The next item is
// accepted in the cycle that the last result of the current one is taken.
// The line store is a single-port-write, registered-read memory; writes and
// reads happen at the acceptance edge, so a read always sees earlier writes.
// Reset clears the fill count and sets every control register to 1; the line
// store content is undefined until written. No clearing pass is needed.
// When the receiver stalls, the current result holds and req_stall stays high
// until the last result of the current item is taken.
// Configuration (csr_*): APB-style, registers at byte address 4*i, bit 0.
module tty_line_discipline (
   input  logic                          clock,
   input  logic                          reset,
   // Input items
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tld_pkg::OP_W-1:0]      req_opcode,
   input  logic [tld_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [tld_pkg::BYTE_W-1:0]    req_read_index,
   // Result items
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tld_pkg::KIND_W-1:0]    rsp_kind,
   output logic [tld_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic [tld_pkg::SIG_W-1:0]     rsp_signal_code,
   output logic [tld_pkg::LEN_W-1:0]     rsp_line_length,
   output logic                          rsp_last,
   // Configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tld_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [tld_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [tld_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import tld_pkg::*;

   // Control registers
   logic display_attached_ff, sig_enable_ff, canonical_mode_ff;
   logic echo_enable_ff, post_process_ff, nl_to_crnl_ff;

   // Line store and its state
   logic [BYTE_W-1:0] line_store_ff [LINE_MAX];
   logic [FILL_W-1:0] fill_count_ff, fill_count_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              in_range_ff;

   // Result stage
   result_type        slot_ff [3];
   result_type        slot_in [3];
   logic [1:0]        cnt_ff, cnt_in;
   logic [1:0]        pos_ff;
   logic              busy_ff;
   logic              is_read_ff, is_read_in;

   // Write port of the line store
   logic              wr_en;
   logic [BYTE_W-1:0] wr_data;

   logic              accept, rsp_take, at_last, csr_write;
   logic [2:0]        csr_index;
   logic [BYTE_W-1:0] key_lf, key_ed;
   logic              is_ctrl, idx_in_range;
   result_type        cur;

   // Handshake
   assign rsp_take  = busy_ff & ~rsp_stall;
   assign at_last   = (pos_ff == 2'(cnt_ff - 2'd1));
   assign req_stall = busy_ff & ~(rsp_take & at_last);
   assign accept    = req_valid & ~req_stall;

   // Key byte decode
   assign is_ctrl = (req_data_byte == CH_INTR) || (req_data_byte == CH_SUSP) ||
                    (req_data_byte == CH_QUIT) || (req_data_byte == CH_FF);
   assign key_lf  = (req_data_byte == CH_CR) ? CH_LF : req_data_byte;
   assign key_ed  = (key_lf == CH_DEL) ? CH_BS : key_lf;
   assign idx_in_range = (32'(req_read_index) < 32'(LINE_MAX));

   // Result generation for the incoming item
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         slot_in[i] = '0;
      end
      cnt_in        = 2'd0;
      is_read_in    = 1'b0;
      fill_count_in = fill_count_ff;
      wr_en         = 1'b0;
      wr_data       = key_ed;
      unique case (req_opcode)
         OP_KEY: begin
            if (display_attached_ff && (req_data_byte != CH_NUL)) begin
               if (is_ctrl) begin
                  if (sig_enable_ff) begin
                     if (req_data_byte == CH_FF) begin
                        slot_in[0].kind     = KIND_DISPLAY;
                        slot_in[0].out_byte = req_data_byte;
                        cnt_in              = 2'd1;
                     end else begin
                        slot_in[0].kind = KIND_SIGNAL;
                        priority if (req_data_byte == CH_INTR) begin
                           slot_in[0].signal_code = SIG_INTR;
                        end else if (req_data_byte == CH_SUSP) begin
                           slot_in[0].signal_code = SIG_STOP;
                        end else begin
                           slot_in[0].signal_code = SIG_QUIT;
                        end
                        slot_in[1].kind     = KIND_DISPLAY;
                        slot_in[1].out_byte = req_data_byte;
                        cnt_in              = 2'd2;
                     end
                  end
               end else if (!canonical_mode_ff) begin
                  // raw: reader byte, then echo
                  slot_in[0].kind     = KIND_READER;
                  slot_in[0].out_byte = key_lf;
                  slot_in[1].kind     = KIND_DISPLAY;
                  slot_in[1].out_byte = key_lf;
                  cnt_in              = echo_enable_ff ? 2'd2 : 2'd1;
               end else if (key_ed == CH_BS) begin
                  // erase; dropped on an empty line
                  if (fill_count_ff != '0) begin
                     fill_count_in       = fill_count_ff - FILL_W'(1);
                     slot_in[0].kind     = KIND_DISPLAY;
                     slot_in[0].out_byte = CH_BS;
                     slot_in[1].kind     = KIND_DISPLAY;
                     slot_in[1].out_byte = CH_SPACE;
                     slot_in[2].kind     = KIND_DISPLAY;
                     slot_in[2].out_byte = CH_BS;
                     cnt_in              = echo_enable_ff ? 2'd3 : 2'd0;
                  end
               end else begin
                  // store byte, echo, maybe complete the line
                  wr_en = 1'b1;
                  if ((key_ed == CH_LF) || (fill_count_ff == FILL_W'(LINE_MAX - 1))) begin
                     fill_count_in = '0;
                     if (echo_enable_ff) begin
                        slot_in[0].kind        = KIND_DISPLAY;
                        slot_in[0].out_byte    = key_ed;
                        slot_in[1].kind        = KIND_LINE;
                        slot_in[1].line_length = LEN_W'(fill_count_ff + FILL_W'(1));
                        cnt_in                 = 2'd2;
                     end else begin
                        slot_in[0].kind        = KIND_LINE;
                        slot_in[0].line_length = LEN_W'(fill_count_ff + FILL_W'(1));
                        cnt_in                 = 2'd1;
                     end
                  end else begin
                     fill_count_in       = fill_count_ff + FILL_W'(1);
                     slot_in[0].kind     = KIND_DISPLAY;
                     slot_in[0].out_byte = key_ed;
                     cnt_in              = echo_enable_ff ? 2'd1 : 2'd0;
                  end
               end
            end
         end
         OP_HOST: begin
            if (post_process_ff && nl_to_crnl_ff && (req_data_byte == CH_LF)) begin
               slot_in[0].kind     = KIND_DISPLAY;
               slot_in[0].out_byte = CH_CR;
               slot_in[1].kind     = KIND_DISPLAY;
               slot_in[1].out_byte = req_data_byte;
               cnt_in              = 2'd2;
            end else begin
               slot_in[0].kind     = KIND_DISPLAY;
               slot_in[0].out_byte = req_data_byte;
               cnt_in              = 2'd1;
            end
         end
         OP_READ: begin
            slot_in[0].kind = KIND_READER;
            is_read_in      = 1'b1;
            cnt_in          = 2'd1;
         end
         default: begin
            cnt_in = 2'd0;
         end
      endcase
   end

   // Line store: write and registered read at the acceptance edge
   always_ff @(posedge clock) begin
      if (accept && (req_opcode == OP_KEY) && wr_en) begin
         line_store_ff[fill_count_ff[ADDR_W-1:0]] <= wr_data;
      end
      if (accept && (req_opcode == OP_READ)) begin
         rd_data_ff  <= line_store_ff[ADDR_W'(req_read_index)];
         in_range_ff <= idx_in_range;
      end
   end

   // Result stage and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pos_ff        <= 2'd0;
         cnt_ff        <= 2'd0;
         is_read_ff    <= 1'b0;
         fill_count_ff <= '0;
      end else begin
         if (accept) begin
            fill_count_ff <= fill_count_in;
         end
         if (accept && (cnt_in != 2'd0)) begin
            busy_ff    <= 1'b1;
            pos_ff     <= 2'd0;
            cnt_ff     <= cnt_in;
            is_read_ff <= is_read_in;
         end else if (rsp_take) begin
            if (at_last) begin
               busy_ff <= 1'b0;
            end else begin
               pos_ff <= pos_ff + 2'd1;
            end
         end
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept && (cnt_in != 2'd0)) begin
         for (int i = 0; i < 3; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   // Result outputs
   always_comb begin
      cur = slot_ff[pos_ff];
      if (is_read_ff) begin
         cur.out_byte = in_range_ff ? rd_data_ff : '0;
      end
   end

   assign rsp_valid       = busy_ff;
   assign rsp_kind        = cur.kind;
   assign rsp_out_byte    = cur.out_byte;
   assign rsp_signal_code = cur.signal_code;
   assign rsp_line_length = cur.line_length;
   assign rsp_last        = at_last;

   // Configuration registers
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         display_attached_ff <= 1'b1;
         sig_enable_ff       <= 1'b1;
         canonical_mode_ff   <= 1'b1;
         echo_enable_ff      <= 1'b1;
         post_process_ff     <= 1'b1;
         nl_to_crnl_ff       <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_DISPLAY_ATTACHED: display_attached_ff <= csr_pwdata[0];
            REG_SIG_ENABLE:       sig_enable_ff       <= csr_pwdata[0];
            REG_CANONICAL_MODE:   canonical_mode_ff   <= csr_pwdata[0];
            REG_ECHO_ENABLE:      echo_enable_ff      <= csr_pwdata[0];
            REG_POST_PROCESS:     post_process_ff     <= csr_pwdata[0];
            REG_NL_TO_CRNL:       nl_to_crnl_ff       <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // Register readback
   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_DISPLAY_ATTACHED: csr_prdata[0] = display_attached_ff;
         REG_SIG_ENABLE:       csr_prdata[0] = sig_enable_ff;
         REG_CANONICAL_MODE:   csr_prdata[0] = canonical_mode_ff;
         REG_ECHO_ENABLE:      csr_prdata[0] = echo_enable_ff;
         REG_POST_PROCESS:     csr_prdata[0] = post_process_ff;
         REG_NL_TO_CRNL:       csr_prdata[0] = nl_to_crnl_ff;
         default:              csr_prdata    = '0;
      endcase
   end

endmodule

// ===== src/tld_checker.sv =====
module tld_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [tld_pkg::KIND_W-1:0] rsp_kind,
   input logic [tld_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic [tld_pkg::SIG_W-1:0]  rsp_signal_code,
   input logic [tld_pkg::LEN_W-1:0]  rsp_line_length,
   input logic                       rsp_last
);
   import tld_pkg::*;

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_kind) && $stable(rsp_out_byte) &&
         $stable(rsp_signal_code) && $stable(rsp_line_length) && $stable(rsp_last))
      else $error("stalled result changed");

   // Input is held back only while a result waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no pending result");

   // A signal is always followed by its display byte
   a_signal_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_SIGNAL) |-> !rsp_last)
      else $error("signal result marked last");

   // Line completion closes its item
   a_line_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_LINE) |-> rsp_last && (rsp_line_length != '0))
      else $error("line complete result not last or empty");

endmodule

bind tty_line_discipline tld_checker u_tld_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_signal_code (rsp_signal_code),
   .rsp_line_length (rsp_line_length),
   .rsp_last        (rsp_last)
);
